>>> design/rsc_pkg.sv
// Shared types, codes and sizes for the RPN stack calculator.
package rsc_pkg;

  localparam int unsigned StackDepthDefault = 128;
  localparam int unsigned QueueDepth        = 2;
  localparam int unsigned DataW             = 32;
  localparam int unsigned LitW              = 31;
  localparam int unsigned CmdW              = 3;
  localparam int unsigned DepthOutW         = 8;

  // Token codes as they arrive on the input channel
  localparam logic [CmdW-1:0] CMD_PUSH = 3'd0;
  localparam logic [CmdW-1:0] CMD_ADD  = 3'd1;
  localparam logic [CmdW-1:0] CMD_SUB  = 3'd2;
  localparam logic [CmdW-1:0] CMD_MULT = 3'd3;
  localparam logic [CmdW-1:0] CMD_DIV  = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_SUB,
    OP_MULT,
    OP_DIV,
    OP_BAD
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_IGNORED,
    ST_OVERFLOW,
    ST_DIVZERO
  } status_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_OPER,
    BK_DIV
  } back_state_e;

  typedef struct packed {
    op_e             op;
    logic [LitW-1:0] literal;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quotient;
  } div_rsp_t;

endpackage

>>> design/rsc_front.sv
// Input side: accepts tokens and decodes them into queue entries.
module rsc_front (
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rsc_pkg::CmdW-1:0]  cmd_i,
  input  logic [rsc_pkg::LitW-1:0]  literal_i,
  input  rsc_pkg::queue_stat_t      stat_i,
  output logic                      push_o,
  output rsc_pkg::token_t           token_o
);

  rsc_pkg::op_e op;

  always_comb begin
    case (cmd_i)
      rsc_pkg::CMD_PUSH: op = rsc_pkg::OP_PUSH;
      rsc_pkg::CMD_ADD:  op = rsc_pkg::OP_ADD;
      rsc_pkg::CMD_SUB:  op = rsc_pkg::OP_SUB;
      rsc_pkg::CMD_MULT: op = rsc_pkg::OP_MULT;
      rsc_pkg::CMD_DIV:  op = rsc_pkg::OP_DIV;
      default:           op = rsc_pkg::OP_BAD;
    endcase
  end

  assign in_ready_o      = !stat_i.full;
  assign push_o          = in_valid_i && !stat_i.full;
  assign token_o.op      = op;
  assign token_o.literal = literal_i;

endmodule

>>> design/rsc_queue.sv
// Short token queue between the decode side and the execute side.
module rsc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rsc_pkg::token_t       token_i,
  input  logic                  pop_i,
  output rsc_pkg::token_t       token_o,
  output rsc_pkg::queue_stat_t  stat_o
);

  localparam int unsigned Depth = rsc_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rsc_pkg::token_t  entries_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wptr_d = push_i ? next_ptr(wptr_q) : wptr_q;
    rptr_d = pop_i  ? next_ptr(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wptr_q] <= token_i;
    end
  end

  assign token_o      = entries_q[rptr_q];
  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> design/rsc_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
module rsc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rsc_pkg::DataW-1:0]  dividend_i,
  input  logic [rsc_pkg::DataW-1:0]  divisor_i,
  output rsc_pkg::div_rsp_t          rsp_o
);

  localparam int unsigned W    = rsc_pkg::DataW;
  localparam int unsigned CntW = $clog2(W + 1);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [W-1:0]    rem_q, den_q, quo_q;
  logic            neg_q;
  logic [W:0]      rem_sh, rem_n;
  logic            ge;

  function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // Restoring step: shift in the next dividend bit, subtract when it fits
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign rem_n  = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(W);
    end else if (busy_q) begin
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= magnitude(dividend_i);
      den_q <= magnitude(divisor_i);
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
    end else if (busy_q) begin
      rem_q <= rem_n[W-1:0];
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = neg_q ? (~quo_q + W'(1)) : quo_q;

endmodule

>>> design/rsc_back.sv
// Execute side: stack memory, top-of-stack register, ALU and result register.
module rsc_back #(
  parameter int unsigned STACK_DEPTH = rsc_pkg::StackDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rsc_pkg::queue_stat_t              stat_i,
  input  rsc_pkg::token_t                   token_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rsc_pkg::DepthOutW-1:0]     depth_o,
  output logic signed [rsc_pkg::DataW-1:0]  top_value_o,
  output logic [1:0]                        status_o
);

  localparam int unsigned W  = rsc_pkg::DataW;
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned OW = rsc_pkg::DepthOutW;

  rsc_pkg::back_state_e state_q, state_d;
  rsc_pkg::op_e         op_q, op_d;
  rsc_pkg::status_e     fin_status;
  rsc_pkg::div_rsp_t    div_rsp;

  logic [DW-1:0] depth_q, depth_d, below1, below2;
  logic [W-1:0]  top_q, top_d, rd_q;
  logic [W-1:0]  sum, diff, prod;
  logic          mem_we, div_start, fin;
  logic [W-1:0]  mem_q [STACK_DEPTH];

  logic          out_valid_q, out_valid_d;
  logic [OW-1:0] out_depth_q, out_depth_d;
  logic [W-1:0]  out_top_q, out_top_d;
  logic [1:0]    out_status_q, out_status_d;

  // The top entry lives in top_q; the memory holds the entries below it
  assign below1 = depth_q - DW'(1);
  assign below2 = depth_q - DW'(2);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[below1[AW-1:0]] <= top_q;
    end
    rd_q <= mem_q[below2[AW-1:0]];
  end

  assign sum  = top_q + rd_q;
  assign diff = rd_q - top_q;
  assign prod = top_q * rd_q;

  rsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd_q),
    .divisor_i  (top_q),
    .rsp_o      (div_rsp)
  );

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    depth_d    = depth_q;
    top_d      = top_q;
    pop_o      = 1'b0;
    mem_we     = 1'b0;
    div_start  = 1'b0;
    fin        = 1'b0;
    fin_status = rsc_pkg::ST_DONE;

    case (state_q)
      rsc_pkg::BK_IDLE: begin
        if (!stat_i.empty && !out_valid_q) begin
          pop_o = 1'b1;
          op_d  = token_i.op;
          case (token_i.op)
            rsc_pkg::OP_PUSH: begin
              fin = 1'b1;
              if (depth_q == DW'(STACK_DEPTH)) begin
                fin_status = rsc_pkg::ST_OVERFLOW;
              end else begin
                mem_we  = (depth_q != '0);
                top_d   = {1'b0, token_i.literal};
                depth_d = depth_q + DW'(1);
              end
            end
            rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MULT, rsc_pkg::OP_DIV: begin
              if (depth_q < DW'(2)) begin
                fin        = 1'b1;
                fin_status = rsc_pkg::ST_IGNORED;
              end else begin
                // second entry arrives in rd_q at this edge
                state_d = rsc_pkg::BK_OPER;
              end
            end
            default: begin
              fin        = 1'b1;
              fin_status = rsc_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      rsc_pkg::BK_OPER: begin
        state_d = rsc_pkg::BK_IDLE;
        case (op_q)
          rsc_pkg::OP_ADD: begin
            fin     = 1'b1;
            top_d   = sum;
            depth_d = below1;
          end
          rsc_pkg::OP_SUB: begin
            fin     = 1'b1;
            top_d   = diff;
            depth_d = below1;
          end
          rsc_pkg::OP_MULT: begin
            fin     = 1'b1;
            top_d   = prod;
            depth_d = below1;
          end
          rsc_pkg::OP_DIV: begin
            if (top_q == '0) begin
              fin        = 1'b1;
              fin_status = rsc_pkg::ST_DIVZERO;
            end else begin
              div_start = 1'b1;
              state_d   = rsc_pkg::BK_DIV;
            end
          end
          default: begin
            fin        = 1'b1;
            fin_status = rsc_pkg::ST_IGNORED;
          end
        endcase
      end
      rsc_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          fin     = 1'b1;
          top_d   = div_rsp.quotient;
          depth_d = below1;
          state_d = rsc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = rsc_pkg::BK_IDLE;
      end
    endcase

    // Result register: drop on acceptance, load on completion
    out_valid_d  = out_valid_q && !out_ready_i;
    out_depth_d  = out_depth_q;
    out_top_d    = out_top_q;
    out_status_d = out_status_q;
    if (fin) begin
      out_valid_d  = 1'b1;
      out_depth_d  = OW'(depth_d);
      out_top_d    = (depth_d == '0) ? '0 : top_d;
      out_status_d = fin_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsc_pkg::BK_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    top_q        <= top_d;
    out_depth_q  <= out_depth_d;
    out_top_q    <= out_top_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o = out_valid_q;
  assign depth_o     = out_depth_q;
  assign top_value_o = out_top_q;
  assign status_o    = out_status_q;

endmodule

>>> design/rpn_stack_calculator.sv
// Top level of the RPN stack calculator: decode, token queue, execute.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   cmd_i, literal_i
//   out      output     out_valid_o / out_ready_i depth_o, top_value_o, status_o
//
// A push, an ignored token or a full-stack push completes in BK_IDLE of the
// execute side; ADD, SUB, MULT end in BK_OPER, once the second entry is read;
// DIV waits in BK_DIV for the one-bit-per-cycle divider (32 steps).
// The execute side starts a token only when its result register is empty;
// the two-entry queue keeps accepting input while a result waits, until full.
// Reset empties the stack and the queue; the stack memory is not cleared.
module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = rsc_pkg::StackDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rsc_pkg::CmdW-1:0]          cmd_i,
  input  logic [rsc_pkg::LitW-1:0]          literal_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rsc_pkg::DepthOutW-1:0]     depth_o,
  output logic signed [rsc_pkg::DataW-1:0]  top_value_o,
  output logic [1:0]                        status_o
);

  rsc_pkg::queue_stat_t q_stat;
  rsc_pkg::token_t      push_token, head_token;
  logic                 q_push, q_pop;

  rsc_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .literal_i  (literal_i),
    .stat_i     (q_stat),
    .push_o     (q_push),
    .token_o    (push_token)
  );

  rsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .token_i (push_token),
    .pop_i   (q_pop),
    .token_o (head_token),
    .stat_o  (q_stat)
  );

  rsc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (q_stat),
    .token_i     (head_token),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .depth_o     (depth_o),
    .top_value_o (top_value_o),
    .status_o    (status_o)
  );

`ifndef SYNTHESIS
  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("token queue popped while empty");

  a_accept_fills_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !q_stat.empty)
    else $error("accepted transaction did not reach the queue");

  a_overflow_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == rsc_pkg::ST_OVERFLOW)
      |-> depth_o == rsc_pkg::DepthOutW'(STACK_DEPTH))
    else $error("overflow reported below a full stack");

  a_empty_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (STACK_DEPTH < 256 && out_valid_o && depth_o == '0) |-> top_value_o == '0)
    else $error("nonzero top value on an empty stack");
`endif

endmodule
